// ===== src/arp_pkg.sv =====
// shared constants and types for the anchor rectangle packer
package arp_pkg;
    localparam int MAX_RECTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;
    localparam int AREA_BITS      = 32;
    localparam int START_RESET    = 256;
    localparam int CFG_IDX_BITS   = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_W = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_H = 8'd1;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_SKIP    = 2'd3;

    typedef struct packed {
        logic done;
        logic free;
    } fit_res_t;
endpackage

// ===== src/arp_fit.sv =====
// placed rectangle store and sequential bounds and overlap checker
module arp_fit #(
    parameter int MAX_RECTS  = arp_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = arp_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [COORD_BITS-1:0]                  cx,
    input  logic [COORD_BITS-1:0]                  cy,
    input  logic [arp_pkg::FIELD_BITS-1:0]         rw,
    input  logic [arp_pkg::FIELD_BITS-1:0]         rh,
    input  logic [COORD_BITS-1:0]                  bin_w,
    input  logic [COORD_BITS-1:0]                  bin_h,
    input  logic [$clog2(MAX_RECTS+1)-1:0]         count,
    input  logic                                   wr_en,
    input  logic [(MAX_RECTS>1 ? $clog2(MAX_RECTS) : 1)-1:0] wr_addr,
    input  logic [COORD_BITS-1:0]                  wr_x,
    input  logic [COORD_BITS-1:0]                  wr_y,
    input  logic [arp_pkg::FIELD_BITS-1:0]         wr_w,
    input  logic [arp_pkg::FIELD_BITS-1:0]         wr_h,
    output arp_pkg::fit_res_t                      res
);
    import arp_pkg::*;

    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int CB    = COORD_BITS;
    localparam int FB    = FIELD_BITS;
    localparam int SW    = ((CB > FB) ? CB : FB) + 1;
    localparam int ENT_W = 2 * CB + 2 * FB;

    typedef enum logic {F_IDLE, F_CMP} fstate_t;

    fstate_t            state_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CB-1:0]      cx_reg, cy_reg;
    logic [FB-1:0]      w_reg, h_reg;
    logic               done_reg, free_reg;
    logic [ENT_W-1:0]   mem [MAX_RECTS];
    logic [ENT_W-1:0]   rdata;
    logic [IDX_W-1:0]   rd_addr;
    logic [CB-1:0]      bx, by;
    logic [FB-1:0]      bw, bh;
    logic               ovl, oob_in, last;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_h, wr_w, wr_y, wr_x};
        end
        rdata <= mem[rd_addr];
    end

    assign rd_addr = (state_reg == F_IDLE) ? '0 : IDX_W'(j_reg + CNT_W'(1));
    assign bx = rdata[CB-1:0];
    assign by = rdata[2*CB-1:CB];
    assign bw = rdata[2*CB+FB-1:2*CB];
    assign bh = rdata[ENT_W-1:2*CB+FB];

    assign ovl = (SW'(cx_reg) < SW'(bx) + SW'(bw)) && (SW'(bx) < SW'(cx_reg) + SW'(w_reg)) &&
                 (SW'(cy_reg) < SW'(by) + SW'(bh)) && (SW'(by) < SW'(cy_reg) + SW'(h_reg));
    assign oob_in = (SW'(cx) + SW'(rw) > SW'(bin_w)) || (SW'(cy) + SW'(rh) > SW'(bin_h));
    assign last = (j_reg + CNT_W'(1)) == count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            free_reg  <= 1'b0;
            j_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE: begin
                    if (start) begin
                        cx_reg <= cx;
                        cy_reg <= cy;
                        w_reg  <= rw;
                        h_reg  <= rh;
                        j_reg  <= '0;
                        if (oob_in) begin
                            done_reg <= 1'b1;
                            free_reg <= 1'b0;
                        end else if (count == '0) begin
                            done_reg <= 1'b1;
                            free_reg <= 1'b1;
                        end else begin
                            state_reg <= F_CMP;
                        end
                    end
                end
                F_CMP: begin
                    if (ovl) begin
                        done_reg  <= 1'b1;
                        free_reg  <= 1'b0;
                        state_reg <= F_IDLE;
                    end else if (last) begin
                        done_reg  <= 1'b1;
                        free_reg  <= 1'b1;
                        state_reg <= F_IDLE;
                    end else begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.free = free_reg;
endmodule

// ===== src/anchor_rect_packer_unit.sv =====
// anchor point rectangle packer top level with anchor list memory and sequencer
// each anchor is checked against the placed rectangles one at a time, then the spot
// slides along x and along y; grow mode doubles the bin and scans the anchors again
// throughput: one request at a time, set by the single placed-store read port;
// a finished result waits in the output register while the next request is taken
// zero width and full store requests go straight to the done state
// reset: bin 256x256, one origin anchor, no placements, area zero; no clearing pass
module anchor_rect_packer_unit #(
    parameter int MAX_RECTS  = arp_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = arp_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // rect_width, rect_height
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // place_x, place_y, bin_width, bin_height, used_area
    output logic [95:0]                       m_tdata,
    output logic [1:0]                        m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [arp_pkg::FIELD_BITS-1:0]    cfg_data
);
    import arp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int FB    = FIELD_BITS;
    localparam int CAP   = MAX_RECTS + 1;
    localparam int AI_W  = $clog2(CAP);
    localparam int AC_W  = $clog2(CAP + 1);
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_AREAD, S_AWAIT, S_RM, S_RMW, S_SLX, S_SLXW, S_SLY, S_SLYW,
        S_STORE, S_INS, S_IFIND, S_IFCMP, S_ISH, S_ISHW, S_INXT, S_DONE
    } state_t;

    state_t            state_reg;
    logic [FB-1:0]     start_w_reg, start_h_reg;
    logic [CB-1:0]     cur_w_reg, cur_h_reg, org_w_reg, org_h_reg;
    logic [CNT_W-1:0]  pc_reg;
    logic [AC_W-1:0]   acnt_reg, ai_reg, p_reg, k_reg;
    logic              a0_zero_reg, rd_zero_reg;
    logic              mode_reg, ins_sel_reg;
    logic [FB-1:0]     w_reg, h_reg;
    logic [AREA_BITS-1:0] prod_reg, area_reg;
    logic [CB-1:0]     ax_reg, ay_reg, sx_reg, sy_reg, px_reg, py_reg, ins_x_reg, ins_y_reg;
    logic [1:0]        status_reg;
    logic              m_valid_reg;
    logic [95:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    logic [2*CB-1:0]   anc_mem [CAP];
    logic [2*CB-1:0]   anc_q, a_rd, a_wdata;
    logic [AI_W-1:0]   a_raddr, a_waddr;
    logic              a_we;
    logic [CB-1:0]     a_x, a_y;

    logic              fit_start;
    logic [CB-1:0]     fit_cx, fit_cy, st_x, st_y;
    fit_res_t          fit_res;
    logic              slide_up, in_acc, cfg_acc;
    logic [CB:0]       nw, nh;

    assign in_acc  = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    // a pending register write goes ahead of a new request
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // anchor list memory, entry zero reads as origin until first written
    always_ff @(posedge aclk) begin
        if (a_we) begin
            anc_mem[a_waddr] <= a_wdata;
        end
        anc_q <= anc_mem[a_raddr];
    end
    assign a_rd = rd_zero_reg ? '0 : anc_q;
    assign a_x  = a_rd[CB-1:0];
    assign a_y  = a_rd[2*CB-1:CB];

    always_comb begin
        case (state_reg)
            S_SCAN:  a_raddr = AI_W'(ai_reg);
            S_RM:    a_raddr = AI_W'(ai_reg + AC_W'(1));
            S_IFIND: a_raddr = AI_W'(p_reg);
            S_ISH:   a_raddr = AI_W'(k_reg - AC_W'(1));
            default: a_raddr = AI_W'(ai_reg);
        endcase
    end

    always_comb begin
        a_we    = 1'b0;
        a_waddr = AI_W'(ai_reg);
        a_wdata = a_rd;
        case (state_reg)
            S_RMW: a_we = 1'b1;
            S_ISHW: begin
                a_we    = 1'b1;
                a_waddr = AI_W'(k_reg);
            end
            S_ISH: begin
                a_we    = (k_reg == p_reg);
                a_waddr = AI_W'(p_reg);
                a_wdata = {ins_y_reg, ins_x_reg};
            end
            default: a_we = 1'b0;
        endcase
    end

    always_comb begin
        fit_start = 1'b0;
        fit_cx    = ax_reg;
        fit_cy    = ay_reg;
        case (state_reg)
            S_AREAD: begin
                fit_start = 1'b1;
                fit_cx    = a_x;
                fit_cy    = a_y;
            end
            S_SLX: begin
                fit_start = (sx_reg != ax_reg);
                fit_cx    = ax_reg - sx_reg - CB'(1);
            end
            S_SLY: begin
                fit_start = (sy_reg != ay_reg);
                fit_cy    = ay_reg - sy_reg - CB'(1);
            end
            default: fit_start = 1'b0;
        endcase
    end

    assign slide_up = sy_reg > sx_reg;
    assign st_x = slide_up ? ax_reg : ax_reg - sx_reg;
    assign st_y = slide_up ? ay_reg - sy_reg : ay_reg;
    assign nw = {cur_w_reg, 1'b0};
    assign nh = {cur_h_reg, 1'b0};

    arp_fit #(.MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS)) u_fit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fit_start),
        .cx      (fit_cx),
        .cy      (fit_cy),
        .rw      (w_reg),
        .rh      (h_reg),
        .bin_w   (cur_w_reg),
        .bin_h   (cur_h_reg),
        .count   (pc_reg),
        .wr_en   (state_reg == S_STORE),
        .wr_addr (IDX_W'(pc_reg)),
        .wr_x    (st_x),
        .wr_y    (st_y),
        .wr_w    (w_reg),
        .wr_h    (h_reg),
        .res     (fit_res)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= AREA_BITS'(w_reg) * AREA_BITS'(h_reg);
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_w_reg <= FB'(START_RESET);
            start_h_reg <= FB'(START_RESET);
            cur_w_reg   <= CB'(START_RESET);
            cur_h_reg   <= CB'(START_RESET);
            pc_reg      <= '0;
            acnt_reg    <= AC_W'(1);
            a0_zero_reg <= 1'b1;
            rd_zero_reg <= 1'b0;
            area_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_zero_reg <= a0_zero_reg && (a_raddr == '0);
            if (a_we && a_waddr == '0) begin
                a0_zero_reg <= 1'b0;
            end
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_acc && (cfg_index == CFG_START_W || cfg_index == CFG_START_H)) begin
                pc_reg      <= '0;
                acnt_reg    <= AC_W'(1);
                a0_zero_reg <= 1'b1;
                area_reg    <= '0;
                if (cfg_index == CFG_START_W) begin
                    start_w_reg <= cfg_data;
                    cur_w_reg   <= CB'(cfg_data);
                    cur_h_reg   <= CB'(start_h_reg);
                end else begin
                    start_h_reg <= cfg_data;
                    cur_w_reg   <= CB'(start_w_reg);
                    cur_h_reg   <= CB'(cfg_data);
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        mode_reg  <= s_tuser;
                        w_reg     <= s_tdata[FB-1:0];
                        h_reg     <= s_tdata[2*FB-1:FB];
                        org_w_reg <= cur_w_reg;
                        org_h_reg <= cur_h_reg;
                        ai_reg    <= '0;
                        px_reg    <= '0;
                        py_reg    <= '0;
                        if (s_tdata[FB-1:0] == '0) begin
                            status_reg <= ST_SKIP;
                            state_reg  <= S_DONE;
                        end else if (pc_reg == CNT_W'(MAX_RECTS)) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (ai_reg == acnt_reg) begin
                        if (!mode_reg) begin
                            status_reg <= ST_NO_ROOM;
                            state_reg  <= S_DONE;
                        end else if (nw[CB] || nh[CB] ||
                                     (cur_w_reg == '0 && cur_h_reg == '0)) begin
                            cur_w_reg  <= org_w_reg;
                            cur_h_reg  <= org_h_reg;
                            status_reg <= ST_NO_ROOM;
                            state_reg  <= S_DONE;
                        end else begin
                            cur_w_reg <= nw[CB-1:0];
                            cur_h_reg <= nh[CB-1:0];
                            ai_reg    <= '0;
                        end
                    end else begin
                        state_reg <= S_AREAD;
                    end
                end
                S_AREAD: begin
                    ax_reg    <= a_x;
                    ay_reg    <= a_y;
                    state_reg <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (fit_res.done) begin
                        if (fit_res.free) begin
                            state_reg <= S_RM;
                        end else begin
                            ai_reg    <= ai_reg + AC_W'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                // close the gap left by the taken anchor
                S_RM: begin
                    if (ai_reg + AC_W'(1) >= acnt_reg) begin
                        acnt_reg  <= acnt_reg - AC_W'(1);
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        state_reg <= S_SLX;
                    end else begin
                        state_reg <= S_RMW;
                    end
                end
                S_RMW: begin
                    ai_reg    <= ai_reg + AC_W'(1);
                    state_reg <= S_RM;
                end
                S_SLX: state_reg <= (sx_reg == ax_reg) ? S_SLY : S_SLXW;
                S_SLXW: begin
                    if (fit_res.done) begin
                        if (fit_res.free) begin
                            sx_reg    <= sx_reg + CB'(1);
                            state_reg <= S_SLX;
                        end else begin
                            state_reg <= S_SLY;
                        end
                    end
                end
                S_SLY: state_reg <= (sy_reg == ay_reg) ? S_STORE : S_SLYW;
                S_SLYW: begin
                    if (fit_res.done) begin
                        if (fit_res.free) begin
                            sy_reg    <= sy_reg + CB'(1);
                            state_reg <= S_SLY;
                        end else begin
                            state_reg <= S_STORE;
                        end
                    end
                end
                S_STORE: begin
                    pc_reg      <= pc_reg + CNT_W'(1);
                    area_reg    <= area_reg + prod_reg;
                    px_reg      <= st_x;
                    py_reg      <= st_y;
                    ins_x_reg   <= st_x;
                    ins_y_reg   <= CB'(st_y + h_reg);
                    ins_sel_reg <= 1'b0;
                    state_reg   <= S_INS;
                end
                S_INS: begin
                    p_reg     <= '0;
                    state_reg <= (acnt_reg >= AC_W'(CAP)) ? S_INXT : S_IFIND;
                end
                S_IFIND: begin
                    if (p_reg == acnt_reg) begin
                        k_reg     <= acnt_reg;
                        state_reg <= S_ISH;
                    end else begin
                        state_reg <= S_IFCMP;
                    end
                end
                // stop at the first anchor with a larger coordinate sum
                S_IFCMP: begin
                    if ({1'b0, a_x} + {1'b0, a_y} <= {1'b0, ins_x_reg} + {1'b0, ins_y_reg}) begin
                        p_reg     <= p_reg + AC_W'(1);
                        state_reg <= S_IFIND;
                    end else begin
                        k_reg     <= acnt_reg;
                        state_reg <= S_ISH;
                    end
                end
                S_ISH: begin
                    if (k_reg == p_reg) begin
                        acnt_reg  <= acnt_reg + AC_W'(1);
                        state_reg <= S_INXT;
                    end else begin
                        state_reg <= S_ISHW;
                    end
                end
                S_ISHW: begin
                    k_reg     <= k_reg - AC_W'(1);
                    state_reg <= S_ISH;
                end
                S_INXT: begin
                    if (!ins_sel_reg) begin
                        ins_sel_reg <= 1'b1;
                        ins_x_reg   <= CB'(px_reg + w_reg);
                        ins_y_reg   <= py_reg;
                        state_reg   <= S_INS;
                    end else begin
                        status_reg <= ST_PLACED;
                        state_reg  <= S_DONE;
                    end
                end
                // hold until the output register is free or being emptied
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= status_reg;
                        m_data_reg  <= {area_reg, FB'(cur_h_reg), FB'(cur_w_reg),
                                        FB'(py_reg), FB'(px_reg)};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_anchor_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        acnt_reg <= AC_W'(CAP))
        else $error("anchor count above capacity");
    a_placed_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= CNT_W'(MAX_RECTS))
        else $error("placed count above capacity");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside done state");
    a_fit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fit_start |-> (state_reg == S_AREAD || state_reg == S_SLX || state_reg == S_SLY))
        else $error("fit check started from wrong state");
`endif
endmodule
